FILE: src/bounded_lifo_stack_core_defines.svh
// Assertion helpers shared by the stack RTL.
// Each one assumes clk and rst_n are visible where it is used.
`ifndef BOUNDED_LIFO_STACK_CORE_DEFINES_SVH
`define BOUNDED_LIFO_STACK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define BLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BLS_ASSERT_NEVER(lbl, expr, msg) \
    `BLS_ASSERT(lbl, !(expr), msg)

`else

`define BLS_ASSERT(lbl, prop, msg)

`define BLS_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: src/bls_pkg.sv
`default_nettype none

package bls_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 10;
    localparam int FILL_W        = 11;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_CHANGE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        status_t                   status;
        logic        [FILL_W-1:0]  fill;
        logic                      is_empty;
    } rsp_t;

    // Everything about a request but its read data, carried one stage.
    typedef struct packed {
        status_t                   status;
        logic        [FILL_W-1:0]  fill;
        logic                      is_empty;
        logic                      use_rd;
    } meta_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

endpackage

`default_nettype wire

FILE: src/bls_ram.sv
`default_nettype none

module bls_ram
    import bls_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic                     clk,
    input  wire mem_cmd_t                 cmd,
    input  wire logic        [AW-1:0]     addr,
    input  wire logic signed [DATA_W-1:0] wdata,
    output      logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Hold the read word until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/bls_ctrl.sv
`default_nettype none
`include "bounded_lifo_stack_core_defines.svh"

module bls_ctrl
    import bls_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire req_t                     req,
    output      mem_cmd_t                 cmd,
    output      logic        [AW-1:0]     addr,
    output      logic signed [DATA_W-1:0] wdata,
    output      meta_t                    meta
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > POS_W) ? FW : POS_W;
    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] top_idx;
    logic [FW-1:0] chg_idx;
    logic          full;
    logic          empty;
    logic          pos_ok;

    assign full    = (fill_reg == DEPTH_F);
    assign empty   = (fill_reg == '0);
    assign top_idx = fill_reg - FW'(1);
    assign chg_idx = top_idx - FW'(req.position);
    assign pos_ok  = (CW'(req.position) < CW'(fill_reg));
    assign wdata   = req.value;

    always_comb
    begin
        fill_next   = fill_reg;
        cmd         = '0;
        addr        = top_idx[AW-1:0];
        meta.status = ST_OK;
        meta.use_rd = 1'b0;
        unique case (req.mode)
            MODE_PUSH:
            begin
                addr = fill_reg[AW-1:0];
                if (full)
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    cmd.we    = accept;
                    fill_next = fill_reg + FW'(1);
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    cmd.re      = accept;
                    meta.use_rd = 1'b1;
                    if (req.mode == MODE_POP)
                    begin
                        fill_next = top_idx;
                    end
                end
            end
            MODE_CHANGE:
            begin
                addr = chg_idx[AW-1:0];
                if (!pos_ok)
                begin
                    meta.status = ST_BADPOS;
                end
                else
                begin
                    cmd.we = accept;
                end
            end
            default:
            begin
                meta.status = ST_OK;
            end
        endcase
        meta.fill     = FILL_W'(fill_next);
        meta.is_empty = (fill_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    `BLS_ASSERT(a_fill_bound, fill_reg <= DEPTH_F, "fill count above depth")
    `BLS_ASSERT_NEVER(a_rd_wr_excl, cmd.we && cmd.re, "read and write in one cycle")
    `BLS_ASSERT(a_push_inc, accept && req.mode == MODE_PUSH && meta.status == ST_OK |=> fill_reg == $past(fill_reg) + FW'(1), "push did not advance fill")
    `BLS_ASSERT(a_idle_hold, !accept |=> fill_reg == $past(fill_reg), "fill moved without a request")

endmodule

`default_nettype wire

FILE: src/bounded_lifo_stack_core.sv
// Channel | Dir | Handshake                | Word
// req     | in  | req_valid / req_ready    | req_t : mode, value, position
// rsp     | out | rsp_valid / rsp_ready    | rsp_t : data, status, fill, is_empty
//
// One request per cycle while req_ready is high. At the accept edge the
// single-port memory is written (push, change) or read (pop, peek), and the
// fill count moves; the result stage registers the result once it is free.
// rst_n clears the fill count and both stage valids; memory contents persist.
// A stalled rsp holds the result stage, and req_ready drops while both stages
// are full and rsp_ready is low.

`default_nettype none
`include "bounded_lifo_stack_core_defines.svh"

module bounded_lifo_stack_core
    import bls_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output      logic req_ready,
    input  wire req_t req,
    output      logic rsp_valid,
    input  wire logic rsp_ready,
    output      rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    mem_cmd_t                 cmd;
    logic        [AW-1:0]     addr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rdata;
    meta_t                    meta;

    logic  accept;
    logic  out_free;
    logic  advance;
    logic  s1_valid_reg;
    logic  s1_valid_next;
    meta_t s1_meta_reg;
    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign advance   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;

    bls_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (cmd),
        .addr   (addr),
        .wdata  (wdata),
        .meta   (meta)
    );

    bls_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Drop the read word for anything but a successful pop or peek.
        rsp_next.data     = s1_meta_reg.use_rd ? rdata : '0;
        rsp_next.status   = s1_meta_reg.status;
        rsp_next.fill     = s1_meta_reg.fill;
        rsp_next.is_empty = s1_meta_reg.is_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BLS_ASSERT(a_data_ok, rsp_valid && rsp.data != '0 |-> rsp.status == ST_OK, "data on failure")
    `BLS_ASSERT(a_empty_fill, rsp_valid && rsp.is_empty |-> rsp.fill == '0, "empty with fill")
    `BLS_ASSERT(a_s1_hold, s1_valid_reg && !out_free |=> s1_valid_reg, "stage lost while stalled")

endmodule

`default_nettype wire

FILE: tb/bounded_lifo_stack_core_tb.sv
module bounded_lifo_stack_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int DEPTH        = DEFAULT_DEPTH;
    localparam int RANDOM_OPS   = 380;
    localparam int STALL_LIMIT  = 2000;
    localparam int OPENING_SIZE = 25;

    // One opening operation; want_* holds the result where it is typed in.
    typedef struct packed {
        mode_t        mode;
        logic [31:0]  value;
        logic [9:0]   position;
        logic         typed;
        logic [31:0]  want_data;
        status_t      want_status;
        logic [10:0]  want_fill;
        logic         want_empty;
    } op_row_t;

    localparam op_row_t OPENING_OPS [OPENING_SIZE] = '{
        '{MODE_POP,    32'h0,        10'h0,   1'b1, 32'h0,        ST_EMPTY,  11'd0, 1'b1},
        '{MODE_PEEK,   32'h0,        10'h0,   1'b1, 32'h0,        ST_EMPTY,  11'd0, 1'b1},
        '{MODE_CHANGE, 32'h5,        10'h0,   1'b1, 32'h0,        ST_BADPOS, 11'd0, 1'b1},
        '{MODE_CHANGE, 32'hFFFFFFFF, 10'h3FF, 1'b1, 32'h0,        ST_BADPOS, 11'd0, 1'b1},
        '{MODE_PUSH,   32'h7FFFFFFF, 10'h3FF, 1'b1, 32'h0,        ST_OK,     11'd1, 1'b0},
        '{MODE_PUSH,   32'h80000000, 10'h0,   1'b1, 32'h0,        ST_OK,     11'd2, 1'b0},
        '{MODE_PEEK,   32'h0,        10'h0,   1'b1, 32'h80000000, ST_OK,     11'd2, 1'b0},
        '{MODE_CHANGE, 32'hFFFFFFFF, 10'h1,   1'b1, 32'h0,        ST_OK,     11'd2, 1'b0},
        '{MODE_CHANGE, 32'h0,        10'h2,   1'b1, 32'h0,        ST_BADPOS, 11'd2, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b1, 32'h80000000, ST_OK,     11'd1, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b1, 32'hFFFFFFFF, ST_OK,     11'd0, 1'b1},
        '{MODE_POP,    32'h0,        10'h0,   1'b1, 32'h0,        ST_EMPTY,  11'd0, 1'b1},
        '{MODE_PUSH,   32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_PUSH,   32'hFFFFFFFF, 10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_PUSH,   32'h55555555, 10'h155, 1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_PUSH,   32'hAAAAAAAA, 10'h2AA, 1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_CHANGE, 32'h12345678, 10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_PEEK,   32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_CHANGE, 32'h7FFFFFFF, 10'h3,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_CHANGE, 32'h1,        10'h4,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_PEEK,   32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0},
        '{MODE_POP,    32'h0,        10'h0,   1'b0, 32'h0,        ST_OK,     11'd0, 1'b0}
    };

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic signed [DATA_W-1:0] word_store [DEPTH];
    int   held_words;
    rsp_t results_owed [$];
    int   fault_count;

    // Typed result that goes with the word now on the request bus.
    bit   lead_typed;
    rsp_t lead_want;

    int   burst_left;
    int   ready_run;
    int   ready_style;

    bounded_lifo_stack_core #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t apply_stack_op(input req_t r);
        rsp_t o;
        o = '0;
        o.status = ST_OK;
        case (r.mode)
            MODE_PUSH:
            begin
                if (held_words >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    word_store[held_words] = r.value;
                    held_words++;
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (held_words == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.data = word_store[held_words - 1];
                    if (r.mode == MODE_POP)
                        held_words--;
                end
            end
            default:
            begin
                if (int'(r.position) >= held_words)
                    o.status = ST_BADPOS;
                else
                    word_store[held_words - 1 - int'(r.position)] = r.value;
            end
        endcase
        o.fill     = held_words[FILL_W-1:0];
        o.is_empty = (held_words == 0);
        return o;
    endfunction

    function automatic req_t random_stack_op();
        req_t r;
        int   pick;
        pick       = $urandom_range(0, 99);
        r.value    = $urandom;
        r.position = POS_W'($urandom_range(0, 1023));
        // lean toward pushes while shallow, toward pops once deeper
        if (pick < ((held_words > 48) ? 30 : 42))
            r.mode = MODE_PUSH;
        else if (pick < 70)
            r.mode = MODE_POP;
        else if (pick < 82)
            r.mode = MODE_PEEK;
        else
        begin
            r.mode = MODE_CHANGE;
            if (held_words > 0 && $urandom_range(0, 3) != 0)
                r.position = POS_W'($urandom_range(0, held_words - 1));
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input req_t w, input bit typed, input rsp_t want);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (idle > 0)
            begin
                req_valid <= 1'b0;
                repeat (idle) @(negedge clk);
            end
        end
        burst_left--;
        req_valid  <= 1'b1;
        req        <= w;
        lead_typed  = typed;
        lead_want   = want;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (results_owed.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: runs of ready high, ready low, or per-cycle coin flips.
    always @(negedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_run   = $urandom_range(1, 20);
            ready_style = $urandom_range(0, 3);
        end
        ready_run--;
        case (ready_style)
            0:       rsp_ready <= 1'b0;
            3:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                got = apply_stack_op(req);
                results_owed.push_back(lead_typed ? lead_want : got);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (results_owed.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got data %0d status %0d",
                             $time, rsp.data, rsp.status);
                    fault_count++;
                end
                else
                begin
                    want = results_owed.pop_front();
                    if (rsp.data !== want.data)
                    begin
                        $display("%0t: data mismatch, expected %0d, got %0d",
                                 $time, want.data, rsp.data);
                        fault_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        fault_count++;
                    end
                    if (rsp.fill !== want.fill)
                    begin
                        $display("%0t: fill mismatch, expected %0d, got %0d",
                                 $time, want.fill, rsp.fill);
                        fault_count++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $display("%0t: is_empty mismatch, expected %0b, got %0b",
                                 $time, want.is_empty, rsp.is_empty);
                        fault_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        wait (rst_n === 1'b1);
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("bounded_lifo_stack_core verification failed");
        $finish;
    end

    initial
    begin
        req_t r;
        rsp_t want;
        int   pick;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        held_words  = 0;
        fault_count = 0;
        lead_typed  = 1'b0;
        lead_want   = '0;
        burst_left  = 0;
        ready_run   = 0;
        ready_style = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_OPS[i])
        begin
            r.mode          = OPENING_OPS[i].mode;
            r.value         = OPENING_OPS[i].value;
            r.position      = OPENING_OPS[i].position;
            want.data       = OPENING_OPS[i].want_data;
            want.status     = OPENING_OPS[i].want_status;
            want.fill       = OPENING_OPS[i].want_fill;
            want.is_empty   = OPENING_OPS[i].want_empty;
            offer(r, OPENING_OPS[i].typed, want);
        end

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == RANDOM_OPS / 2)
                hold_until_drained();
            offer(random_stack_op(), 1'b0, '0);
        end

        // Unwind what is left, then pop the empty stack once more.
        r.position = '0;
        while (held_words > 0)
        begin
            pick       = $urandom_range(0, 9);
            r.value    = $urandom;
            r.position = POS_W'($urandom_range(0, held_words - 1));
            r.mode     = (pick < 8) ? MODE_POP : (pick == 8) ? MODE_PEEK : MODE_CHANGE;
            offer(r, 1'b0, '0);
        end
        r.mode = MODE_POP;
        offer(r, 1'b0, '0);

        req_valid <= 1'b0;
        while (results_owed.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fault_count == 0 && results_owed.size() == 0)
            $display("bounded_lifo_stack_core verification clean");
        else
            $display("bounded_lifo_stack_core verification failed");
        $finish;
    end

endmodule
